// ===== hdl/min_window_cover_search_macros.svh =====
// Assertion macros shared by the minimum window cover search modules.
`ifndef MIN_WINDOW_COVER_SEARCH_MACROS_SVH
`define MIN_WINDOW_COVER_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define MWCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MWCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MWCS_ASSERT_IMP(lbl, ante, cons, msg)
`define MWCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/mwcs_pkg.sv =====
// Shared constants and types of the minimum window cover search.
`timescale 1ns / 1ps
package mwcs_pkg;

	localparam int MAX_TEXT_DEF    = 1024;
	localparam int MAX_PATTERN_DEF = 1024;
	localparam int ALPHABET_DEF    = 256;

	localparam int CH_W     = 8;
	localparam int START_W  = 10;
	localparam int LENGTH_W = 11;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic in_idle;
		logic accept_pat;
		logic accept_txt;
		logic upd_pat;
		logic upd_txt;
		logic shrink;
		logic emit;
	} mwcs_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic pat_full;
		logic txt_full;
		logic can_shrink;
	} mwcs_sts_t;

endpackage

// ===== hdl/mwcs_ifs.sv =====
// Item and result channel interfaces of the minimum window cover search.
`timescale 1ns / 1ps
interface mwcs_item_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [mwcs_pkg::CH_W-1:0] ch;
	logic                      last;

	modport source (output valid, output cmd, output ch, output last, input ready);
	modport sink (input valid, input cmd, input ch, input last, output ready);
endinterface

interface mwcs_result_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [mwcs_pkg::START_W-1:0]  start_res;
	logic [mwcs_pkg::LENGTH_W-1:0] length;
	logic                          overflow;

	modport source (output valid, output found, output start_res, output length,
		output overflow, input ready);
	modport sink (input valid, input found, input start_res, input length,
		input overflow, output ready);
endinterface

// ===== hdl/min_window_cover_search.sv =====
// Top level of the minimum window cover search.
//
//  channel | direction | payload                              | request
//  item    | sink      | cmd, ch, last                        | one pattern or text byte
//  result  | source    | found, start_res, length, overflow   | one answer per final text byte
//
// A pattern byte is handled as an accept, then a read-modify-write of its deficit count.
// A text byte is accepted, updated and then checked, and each step of the left edge adds
// a shrink and another check; a final byte then loads the result register. The deficit
// count memory has one registered read port.
// Reset and each result clear all deficit counts at once through per-symbol valid bits.
// A waiting result does not stall the input; a second result waits until the first is taken.
`timescale 1ns / 1ps
module min_window_cover_search #(
	parameter int MAX_TEXT    = mwcs_pkg::MAX_TEXT_DEF,
	parameter int MAX_PATTERN = mwcs_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = mwcs_pkg::ALPHABET_DEF
) (
	input logic            clk,
	input logic            arst_n,
	mwcs_item_if.sink      item,
	mwcs_result_if.source  result
);

	mwcs_pkg::mwcs_cmd_t ctl;
	mwcs_pkg::mwcs_sts_t sts;

	mwcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.item_cmd     (item.cmd),
		.item_last    (item.last),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.ctl          (ctl),
		.sts          (sts)
	);

	mwcs_datapath #(
		.MAX_TEXT    (MAX_TEXT),
		.MAX_PATTERN (MAX_PATTERN),
		.ALPHABET    (ALPHABET)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.ch        (item.ch),
		.found     (result.found),
		.start_res (result.start_res),
		.length    (result.length),
		.overflow  (result.overflow)
	);

endmodule

// ===== hdl/mwcs_ctrl.sv =====
// Sequencer of the minimum window cover search.
`timescale 1ns / 1ps
`include "min_window_cover_search_macros.svh"
module mwcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                item_cmd,
	input  logic                item_last,
	output logic                result_valid,
	input  logic                result_ready,
	output mwcs_pkg::mwcs_cmd_t ctl,
	input  mwcs_pkg::mwcs_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAT    = 3'd1;
	localparam logic [2:0] ST_TXT    = 3'd2;
	localparam logic [2:0] ST_CHK    = 3'd3;
	localparam logic [2:0] ST_SHRINK = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign slot_free    = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		ctl            = '0;
		ctl.in_idle    = (state_q == ST_IDLE);
		ctl.accept_pat = accept && (item_cmd == mwcs_pkg::CMD_PATTERN);
		ctl.accept_txt = accept && (item_cmd == mwcs_pkg::CMD_TEXT);
		ctl.upd_pat    = (state_q == ST_PAT);
		ctl.upd_txt    = (state_q == ST_TXT);
		ctl.shrink     = (state_q == ST_SHRINK);
		ctl.emit       = (state_q == ST_EMIT) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item_cmd == mwcs_pkg::CMD_PATTERN) begin
						state_d = sts.pat_full ? ST_IDLE : ST_PAT;
					end else if (!sts.txt_full) begin
						state_d = ST_TXT;
					end else begin
						state_d = item_last ? ST_EMIT : ST_IDLE;
					end
				end
			end
			ST_PAT:    state_d = ST_IDLE;
			ST_TXT:    state_d = ST_CHK;
			ST_CHK: begin
				if (sts.can_shrink) begin
					state_d = ST_SHRINK;
				end else begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_SHRINK: state_d = ST_CHK;
			ST_EMIT:   state_d = slot_free ? ST_IDLE : ST_EMIT;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= item_last;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MWCS_ASSERT_IMP(a_emit_slot_free, ctl.emit, !out_valid_q || result_ready, "result overwritten")
	`MWCS_ASSERT_IMP(a_shrink_checked, state_q == ST_SHRINK, $past(state_q) == ST_CHK && $past(sts.can_shrink), "shrink without check")
	`MWCS_ASSERT_NXT(a_text_then_check, state_q == ST_TXT, state_q == ST_CHK, "text update not followed by check")

endmodule

// ===== hdl/mwcs_datapath.sv =====
// Datapath of the minimum window cover search: text store, deficit counts, edges, best window.
`timescale 1ns / 1ps
`include "min_window_cover_search_macros.svh"
module mwcs_datapath #(
	parameter int MAX_TEXT    = mwcs_pkg::MAX_TEXT_DEF,
	parameter int MAX_PATTERN = mwcs_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = mwcs_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mwcs_pkg::mwcs_cmd_t           ctl,
	output mwcs_pkg::mwcs_sts_t           sts,
	input  logic [mwcs_pkg::CH_W-1:0]     ch,
	output logic                          found,
	output logic [mwcs_pkg::START_W-1:0]  start_res,
	output logic [mwcs_pkg::LENGTH_W-1:0] length,
	output logic                          overflow
);

	localparam int IDX_W  = $clog2(MAX_TEXT);
	localparam int CNT_W  = $clog2(MAX_TEXT + 1);
	localparam int LEN_W  = $clog2(MAX_TEXT + 2);
	localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int LACK_W = $clog2(ALPHABET + 1);
	localparam int D_MAX  = (MAX_TEXT > MAX_PATTERN) ? MAX_TEXT : MAX_PATTERN;
	localparam int D_W    = $clog2(D_MAX + 1) + 1;
	localparam int SX_W   = (IDX_W > mwcs_pkg::START_W) ? IDX_W : mwcs_pkg::START_W;
	localparam int LX_W   = (LEN_W > mwcs_pkg::LENGTH_W) ? LEN_W : mwcs_pkg::LENGTH_W;

	// Reduce a byte into the alphabet by shifted compare and subtract.
	function automatic logic [SYM_W-1:0] sym_of(input logic [mwcs_pkg::CH_W-1:0] c);
		logic [15:0] r;
		r = 16'(c);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (16'(ALPHABET) << k)) begin
				r = r - (16'(ALPHABET) << k);
			end
		end
		return r[SYM_W-1:0];
	endfunction

	// Deficit per symbol is need count minus have count; positive means lacking.
	logic signed [D_W-1:0] def_mem [ALPHABET];
	logic                  def_vld_q [ALPHABET];
	logic signed [D_W-1:0] def_rd_q;
	logic                  def_rdv_q;
	logic [SYM_W-1:0]      text_mem [MAX_TEXT];
	logic [SYM_W-1:0]      text_rd_q;

	logic [SYM_W-1:0]      sym_in;
	logic [SYM_W-1:0]      sym_q;
	logic [CNT_W-1:0]      left_q;
	logic [CNT_W-1:0]      right_q;
	logic [CNT_W-1:0]      left_plus;
	logic [CNT_W-1:0]      win_len;
	logic [PLEN_W-1:0]     plen_q;
	logic [LACK_W-1:0]     lacking_q;
	logic [LEN_W-1:0]      best_len_q;
	logic [IDX_W-1:0]      best_start_q;
	logic                  overflow_q;

	logic [SYM_W-1:0]      def_raddr;
	logic [SYM_W-1:0]      def_waddr;
	logic                  def_we;
	logic signed [D_W-1:0] d_cur;
	logic signed [D_W-1:0] d_new;
	logic                  lack_inc;
	logic                  lack_dec;
	logic [IDX_W-1:0]      text_raddr;
	logic                  text_we;
	logic                  found_now;
	logic [SX_W-1:0]       start_ext;
	logic [LX_W-1:0]       len_ext;

	logic                  res_found_q;
	logic [mwcs_pkg::START_W-1:0]  res_start_q;
	logic [mwcs_pkg::LENGTH_W-1:0] res_len_q;
	logic                  res_ovf_q;

	assign sym_in    = sym_of(ch);
	assign left_plus = left_q + 1'b1;
	assign win_len   = right_q - left_q;

	assign sts.pat_full   = (plen_q >= PLEN_W'(MAX_PATTERN));
	assign sts.txt_full   = (right_q >= CNT_W'(MAX_TEXT));
	assign sts.can_shrink = (plen_q != '0) && (lacking_q == '0) && (left_q < right_q);

	// While a left-edge step is in progress the next text symbol is fetched early.
	assign text_raddr = ctl.shrink ? left_plus[IDX_W-1:0] : left_q[IDX_W-1:0];
	assign text_we    = ctl.accept_txt && !sts.txt_full;

	assign def_raddr = ctl.in_idle ? sym_in : text_rd_q;
	assign def_waddr = ctl.shrink ? text_rd_q : sym_q;
	assign def_we    = ctl.upd_pat || ctl.upd_txt || ctl.shrink;
	assign d_cur     = def_rdv_q ? def_rd_q : '0;

	always_comb begin
		d_new    = d_cur;
		lack_inc = 1'b0;
		lack_dec = 1'b0;
		if (ctl.upd_pat) begin
			d_new    = d_cur + D_W'(1);
			lack_inc = (d_cur == '0);
		end else if (ctl.upd_txt) begin
			d_new    = d_cur - D_W'(1);
			lack_dec = (d_new == '0);
		end else if (ctl.shrink) begin
			d_new    = d_cur + D_W'(1);
			lack_inc = (d_new == D_W'(1));
		end
	end

	assign found_now = (plen_q != '0) && (right_q != '0) && (LEN_W'(right_q) >= best_len_q);
	assign start_ext = SX_W'(best_start_q);
	assign len_ext   = LX_W'(best_len_q);

	always_ff @(posedge clk) begin
		if (text_we) begin
			text_mem[right_q[IDX_W-1:0]] <= sym_in;
		end
		text_rd_q <= text_mem[text_raddr];
	end

	always_ff @(posedge clk) begin
		if (def_we) begin
			def_mem[def_waddr] <= d_new;
		end
		def_rd_q  <= def_mem[def_raddr];
		def_rdv_q <= def_vld_q[def_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.accept_pat || ctl.accept_txt) begin
			sym_q <= sym_in;
		end
		if (ctl.emit) begin
			res_found_q <= found_now;
			res_start_q <= found_now ? start_ext[mwcs_pkg::START_W-1:0] : '0;
			res_len_q   <= found_now ? len_ext[mwcs_pkg::LENGTH_W-1:0] : '0;
			res_ovf_q   <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET; i++) begin
				def_vld_q[i] <= 1'b0;
			end
		end else if (ctl.emit) begin
			for (int i = 0; i < ALPHABET; i++) begin
				def_vld_q[i] <= 1'b0;
			end
		end else if (def_we) begin
			def_vld_q[def_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			right_q      <= '0;
			plen_q       <= '0;
			lacking_q    <= '0;
			best_len_q   <= LEN_W'(MAX_TEXT + 1);
			best_start_q <= '0;
			overflow_q   <= 1'b0;
		end else if (ctl.emit) begin
			left_q       <= '0;
			right_q      <= '0;
			plen_q       <= '0;
			lacking_q    <= '0;
			best_len_q   <= LEN_W'(MAX_TEXT + 1);
			best_start_q <= '0;
			overflow_q   <= 1'b0;
		end else begin
			if (ctl.accept_pat) begin
				if (sts.pat_full) begin
					overflow_q <= 1'b1;
				end else begin
					plen_q <= plen_q + 1'b1;
				end
			end
			if (ctl.accept_txt) begin
				if (sts.txt_full) begin
					overflow_q <= 1'b1;
				end else begin
					right_q <= right_q + 1'b1;
				end
			end
			if (lack_inc) begin
				lacking_q <= lacking_q + 1'b1;
			end else if (lack_dec) begin
				lacking_q <= lacking_q - 1'b1;
			end
			if (ctl.shrink) begin
				left_q <= left_plus;
				// Only a strictly shorter window replaces the best one.
				if (LEN_W'(win_len) < best_len_q) begin
					best_len_q   <= LEN_W'(win_len);
					best_start_q <= left_q[IDX_W-1:0];
				end
			end
		end
	end

	assign found     = res_found_q;
	assign start_res = res_start_q;
	assign length    = res_len_q;
	assign overflow  = res_ovf_q;

	`MWCS_ASSERT_IMP(a_edges_ordered, 1'b1, left_q <= right_q, "left edge passed right edge")
	`MWCS_ASSERT_IMP(a_lacking_bound, 1'b1, lacking_q <= LACK_W'(ALPHABET), "lacking count out of range")
	`MWCS_ASSERT_NXT(a_emit_clears, ctl.emit, right_q == '0 && plen_q == '0 && !overflow_q, "problem state not cleared")

endmodule

// ===== tb/window_answer_checker.sv =====
// Checker of the minimum window cover search: predicts each answer and compares it field by field.
`timescale 1ns / 1ps
module window_answer_checker (
	input  logic   clk,
	input  logic   arst_n,
	mwcs_item_if   item_mon,
	mwcs_result_if result_mon,
	output int     mismatches,
	output int     waiting,
	output int     compared
);
	import mwcs_pkg::*;

	localparam int TEXT_DEPTH = MAX_TEXT_DEF;
	localparam int PAT_DEPTH  = MAX_PATTERN_DEF;
	localparam int SYMBOLS    = ALPHABET_DEF;

	typedef struct packed {
		logic                found;
		logic [START_W-1:0]  start_res;
		logic [LENGTH_W-1:0] length;
		logic                overflow;
	} cover_answer_t;

	// Own copy of the problem state; edges, best window and counters at the widths of the block.
	logic [10:0]     need_tally [SYMBOLS];
	logic [10:0]     have_tally [SYMBOLS];
	logic [8:0]      short_kinds;
	logic [CH_W-1:0] text_copy [TEXT_DEPTH];
	logic [10:0]     win_lo;
	logic [10:0]     win_hi;
	logic [10:0]     best_len;
	logic [9:0]      best_lo;
	logic            ovf_flag;
	logic [10:0]     pat_total;

	cover_answer_t answers_due [$];
	int            err_total;
	int            answers_checked;

	task automatic clear_problem();
		for (int s = 0; s < SYMBOLS; s++) begin
			need_tally[s] = '0;
			have_tally[s] = '0;
		end
		short_kinds = '0;
		win_lo      = '0;
		win_hi      = '0;
		best_len    = 11'(TEXT_DEPTH + 1);
		best_lo     = '0;
		ovf_flag    = 1'b0;
		pat_total   = '0;
	endtask

	// Pulls the left edge in for as long as the window still covers the pattern.
	task automatic narrow_window();
		logic [CH_W-1:0] sym;
		while (pat_total != 0 && short_kinds == 0 && win_lo < win_hi) begin
			if (win_hi - win_lo < best_len) begin
				best_len = win_hi - win_lo;
				best_lo  = win_lo[9:0];
			end
			sym = text_copy[win_lo];
			if (have_tally[sym] != 0)
				have_tally[sym] = have_tally[sym] - 11'd1;
			if (have_tally[sym] + 11'd1 == need_tally[sym])
				short_kinds = short_kinds + 9'd1;
			win_lo = win_lo + 11'd1;
		end
	endtask

	task automatic absorb_request(input logic c, input logic [CH_W-1:0] b, input logic l);
		cover_answer_t ans;
		if (c == CMD_PATTERN) begin
			if (pat_total >= PAT_DEPTH) begin
				ovf_flag = 1'b1;
			end else begin
				pat_total = pat_total + 11'd1;
				if (have_tally[b] == need_tally[b])
					short_kinds = short_kinds + 9'd1;
				need_tally[b] = need_tally[b] + 11'd1;
			end
		end else begin
			if (win_hi >= TEXT_DEPTH) begin
				ovf_flag = 1'b1;
			end else begin
				text_copy[win_hi] = b;
				win_hi = win_hi + 11'd1;
				have_tally[b] = have_tally[b] + 11'd1;
				if (have_tally[b] == need_tally[b])
					short_kinds = short_kinds - 9'd1;
				narrow_window();
			end
			if (l) begin
				ans.found     = (pat_total != 0 && win_hi != 0 && best_len <= win_hi);
				ans.start_res = ans.found ? best_lo : '0;
				ans.length    = ans.found ? best_len : '0;
				ans.overflow  = ovf_flag;
				answers_due.push_back(ans);
				clear_problem();
			end
		end
	endtask

	task automatic compare_answer();
		cover_answer_t want;
		if (answers_due.size() == 0) begin
			$error("answer with none expected: found %0d start_res %0d length %0d overflow %0d",
				result_mon.found, result_mon.start_res, result_mon.length, result_mon.overflow);
			err_total++;
		end else begin
			want = answers_due.pop_front();
			if (result_mon.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, result_mon.found);
				err_total++;
			end
			if (result_mon.start_res !== want.start_res) begin
				$error("start_res: expected %0d, actual %0d", want.start_res, result_mon.start_res);
				err_total++;
			end
			if (result_mon.length !== want.length) begin
				$error("length: expected %0d, actual %0d", want.length, result_mon.length);
				err_total++;
			end
			if (result_mon.overflow !== want.overflow) begin
				$error("overflow: expected %0d, actual %0d", want.overflow, result_mon.overflow);
				err_total++;
			end
			answers_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_problem();
			answers_due.delete();
			err_total       = 0;
			answers_checked = 0;
			mismatches <= 0;
			waiting    <= 0;
			compared   <= 0;
		end else begin
			// An answer taken now always stems from an earlier request, so it is checked first.
			if (result_mon.valid && result_mon.ready)
				compare_answer();
			if (item_mon.valid && item_mon.ready)
				absorb_request(item_mon.cmd, item_mon.ch, item_mon.last);
			mismatches <= err_total;
			waiting    <= answers_due.size();
			compared   <= answers_checked;
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Top of the minimum window cover search testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb_top;
	import mwcs_pkg::*;

	logic clk;
	logic arst_n = 1'b0;

	int send_idle;
	int recv_idle;
	int requests_sent;
	int mismatch_total;
	int answers_waiting;
	int answers_compared;

	logic [CH_W-1:0] letter_set [4];
	int              letter_count;
	bit              letter_wide;

	mwcs_item_if   item_ch ();
	mwcs_result_if result_ch ();

	min_window_cover_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	window_answer_checker answer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.result_mon (result_ch),
		.mismatches (mismatch_total),
		.waiting    (answers_waiting),
		.compared   (answers_compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Valid stays high from one request to the next unless a gap is drawn.
	task automatic send_request(input logic c, input logic [CH_W-1:0] b, input logic l);
		while ($urandom_range(0, 99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd   <= c;
		item_ch.ch    <= b;
		item_ch.last  <= l;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic play_strings(input string pat, input string txt);
		for (int i = 0; i < pat.len(); i++)
			send_request(CMD_PATTERN, pat[i], 1'b0);
		for (int i = 0; i < txt.len(); i++)
			send_request(CMD_TEXT, txt[i], i == txt.len() - 1);
	endtask

	function automatic logic [CH_W-1:0] draw_symbol();
		if (letter_wide)
			return CH_W'($urandom_range(0, 255));
		return letter_set[$urandom_range(0, letter_count - 1)];
	endfunction

	// Small problems over a narrow alphabet so that covers are common; a few carry
	// ignored last bits, stray pattern bytes among the text or full-range bytes.
	task automatic random_problem();
		int pat_len;
		int txt_len;
		int mid_pat;
		for (int i = 0; i < 4; i++)
			letter_set[i] = CH_W'($urandom_range(0, 255));
		letter_count = $urandom_range(1, 4);
		letter_wide  = ($urandom_range(0, 7) == 0);
		pat_len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
		txt_len = $urandom_range(1, 32);
		mid_pat = ($urandom_range(0, 9) == 0) ? $urandom_range(0, txt_len - 1) : -1;
		for (int i = 0; i < pat_len; i++)
			send_request(CMD_PATTERN, draw_symbol(), $urandom_range(0, 7) == 0);
		for (int i = 0; i < txt_len; i++) begin
			if (i == mid_pat)
				send_request(CMD_PATTERN, draw_symbol(), 1'b0);
			send_request(CMD_TEXT, draw_symbol(), i == txt_len - 1);
		end
	endtask

	initial begin
		send_idle     = 18;
		recv_idle     = 72;
		requests_sent = 0;
		item_ch.valid <= 1'b0;
		item_ch.cmd   <= CMD_PATTERN;
		item_ch.ch    <= '0;
		item_ch.last  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern.
		play_strings("", "q");
		// Extreme byte values, with a last bit on a pattern byte that must be ignored.
		send_request(CMD_PATTERN, 8'h00, 1'b1);
		send_request(CMD_PATTERN, 8'hff, 1'b0);
		send_request(CMD_TEXT, 8'hff, 1'b0);
		send_request(CMD_TEXT, 8'h41, 1'b0);
		send_request(CMD_TEXT, 8'h00, 1'b1);
		// Repeated pattern symbols, then a pattern that is never covered.
		play_strings("aab", "xaybaab");
		play_strings("zz", "az");
		// A pattern byte that arrives after text bytes.
		send_request(CMD_TEXT, "a", 1'b0);
		send_request(CMD_TEXT, "b", 1'b0);
		send_request(CMD_PATTERN, "c", 1'b0);
		send_request(CMD_TEXT, "c", 1'b0);
		send_request(CMD_TEXT, "b", 1'b1);

		while (requests_sent < 300)
			random_problem();
		send_idle = 72;
		recv_idle = 18;
		while (requests_sent < 575)
			random_problem();
		send_idle = 0;
		recv_idle = 0;
		while (requests_sent < 850)
			random_problem();
		item_ch.valid <= 1'b0;

		@(posedge clk);
		while (answers_waiting != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("tb_top: %0d requests sent, %0d answers compared", requests_sent,
			answers_compared);
		$display("tb_top: covered empty and late patterns, repeats, misses and extreme bytes");
		if (mismatch_total == 0 && answers_waiting == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mwcs_pkg.sv
hdl/mwcs_ifs.sv
hdl/mwcs_ctrl.sv
hdl/mwcs_datapath.sv
hdl/min_window_cover_search.sv
tb/window_answer_checker.sv
tb/tb_top.sv
